// ===== src/nmea_rmc_time_clock_core_defines.svh =====
// Assertion macros shared by the verification files of the NMEA RMC time clock.
// Needs nothing else; each macro samples on the rising edge of the given clock.
`ifndef NMEA_RMC_TIME_CLOCK_CORE_DEFINES_SVH
`define NMEA_RMC_TIME_CLOCK_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NRTC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NRTC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/nrtc_pkg.sv =====
// Shared types and constants of the NMEA RMC time clock.
// No dependencies; imported by the top level, nrtc_parse, nrtc_disp and the testbench.
`default_nettype none

package nrtc_pkg;

    localparam int CAPTURE_LIMIT = 16;
    localparam int FCW           = $clog2(CAPTURE_LIMIT + 1);

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_P      = 8'h50;
    localparam logic [7:0] CHAR_R      = 8'h52;
    localparam logic [7:0] CHAR_M      = 8'h4D;
    localparam logic [7:0] CHAR_C      = 8'h43;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;

    // Parser state codes: header positions, time capture, result emit.
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_HDR_LAST = 4'd6;
    localparam logic [3:0] ST_CAPTURE  = 4'd7;
    localparam logic [3:0] ST_EMIT     = 4'd8;

    localparam logic [3:0] TZ_RESET = 4'd4;

    typedef struct packed {
        logic       hour_tens;
        logic [3:0] hour_ones;
        logic [3:0] minute_tens;
        logic [3:0] minute_ones;
    } t_digits;

    localparam t_digits DIGITS_RESET = '{1'b1, 4'd2, 4'd3, 4'd4};

    typedef struct packed {
        logic    emit;
        t_digits digits;
    } t_emit;

    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CHAR_DOLLAR;
            3'd1:    c = CHAR_G;
            3'd2:    c = CHAR_P;
            3'd3:    c = CHAR_R;
            3'd4:    c = CHAR_M;
            3'd5:    c = CHAR_C;
            default: c = CHAR_COMMA;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/nmea_rmc_time_clock_core.sv =====
// Top level of the NMEA RMC time clock: input register, timezone register, parser, display.
// Depends on nrtc_pkg, nrtc_parse, nrtc_hour and nrtc_disp.
`default_nettype none

// The block takes one received character per clock while o_stall is low and
// watches for a $GPRMC sentence; the word after the comma that closes the time
// field produces one result with the local 12-hour time digits, a change flag,
// a blink level and a leading-blank flag. Every other word produces no result.
// A word is held in the input register and its result, if any, appears from
// the result register; a new word can be taken every cycle unless stalled, as
// the result register alone sets that rate and only a stalled result that is
// still waiting holds off the next word.
// The timezone register resets to 4 and may be written whenever the port is idle.

module nmea_rmc_time_clock_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [3:0] i_cfg_data,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_hour_tens,
    output logic [3:0]      o_hour_ones,
    output logic [3:0]      o_minute_tens,
    output logic [3:0]      o_minute_ones,
    output logic            o_changed,
    output logic            o_blink_level,
    output logic            o_blank_lead
);
    import nrtc_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [3:0]  r_tz;
    logic        adv;
    logic        proc;
    logic        accept;
    t_emit       emit;

    assign adv         = !o_valid || !i_stall;
    assign proc        = r_in_valid && adv;
    assign o_stall     = r_in_valid && !adv;
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_tz       <= TZ_RESET;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_tz <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    nrtc_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step_en (proc),
        .i_byte    (r_in_byte),
        .i_tz      (r_tz),
        .o_emit    (emit)
    );

    nrtc_disp u_disp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_proc        (proc),
        .i_adv         (adv),
        .i_emit        (emit),
        .o_valid       (o_valid),
        .o_hour_tens   (o_hour_tens),
        .o_hour_ones   (o_hour_ones),
        .o_minute_tens (o_minute_tens),
        .o_minute_ones (o_minute_ones),
        .o_changed     (o_changed),
        .o_blink_level (o_blink_level),
        .o_blank_lead  (o_blank_lead)
    );

endmodule

`default_nettype wire

// ===== src/nrtc_hour.sv =====
// Hour conversion: UTC hour nibbles to a 12-hour local hour split into digits.
// Depends on nothing but its ports.
`default_nettype none

module nrtc_hour (
    input  wire logic [3:0] i_tens_nib,
    input  wire logic [3:0] i_ones_nib,
    input  wire logic [3:0] i_tz,
    output logic            o_tens,
    output logic [3:0]      o_ones
);
    logic [7:0] hr;
    logic [7:0] hr12;
    logic [8:0] adj;
    logic [8:0] local_hr;
    logic [8:0] minus_ten;

    always_comb begin
        hr       = {1'b0, i_tens_nib, 3'b000} + {3'b000, i_tens_nib, 1'b0} + {4'b0000, i_ones_nib};
        hr12     = (hr > 8'd12) ? (hr - 8'd12) : hr;
        adj      = (hr12 <= {4'b0000, i_tz}) ? 9'd12 : 9'd0;
        // Bit 8 set means the subtraction went below zero, which counts as large.
        local_hr = {1'b0, hr12} + adj - {5'b00000, i_tz};
        minus_ten = local_hr - 9'd10;
        o_tens   = local_hr[8] || (local_hr[7:0] > 8'd9);
        o_ones   = o_tens ? minus_ten[3:0] : local_hr[3:0];
    end

endmodule

`default_nettype wire

// ===== src/nrtc_parse.sv =====
// Sentence parser: header matcher, time field capture and pending digits.
// Depends on nrtc_pkg and nrtc_hour.
`default_nettype none

module nrtc_parse (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step_en,
    input  wire logic [7:0]     i_byte,
    input  wire logic [3:0]     i_tz,
    output nrtc_pkg::t_emit     o_emit
);
    import nrtc_pkg::*;

    logic [3:0]       r_step,  n_step;
    logic [FCW-1:0]   r_count, n_count;
    logic [3:0][3:0]  r_nib,   n_nib;
    t_digits          r_pend,  n_pend;
    logic             hr_tens;
    logic [3:0]       hr_ones;

    nrtc_hour u_hour (
        .i_tens_nib (r_nib[0]),
        .i_ones_nib (r_nib[1]),
        .i_tz       (i_tz),
        .o_tens     (hr_tens),
        .o_ones     (hr_ones)
    );

    always_comb begin
        n_step  = r_step;
        n_count = r_count;
        n_nib   = r_nib;
        n_pend  = r_pend;
        unique case (r_step) inside
            [ST_IDLE:ST_HDR_LAST]: begin
                if (r_step == ST_HDR_LAST) begin
                    n_count = '0;
                end
                n_step = (i_byte == hdr_char(r_step[2:0])) ? (r_step + 4'd1) : ST_IDLE;
            end
            ST_CAPTURE: begin
                if (i_byte == CHAR_COMMA) begin
                    // A time field of seven bytes or fewer shows as all zeros.
                    if (r_count > FCW'(7)) begin
                        n_pend = '{hr_tens, hr_ones, r_nib[2], r_nib[3]};
                    end else begin
                        n_pend = '0;
                    end
                    n_count = '0;
                    n_step  = ST_EMIT;
                end else if (r_count < FCW'(CAPTURE_LIMIT)) begin
                    if (r_count < FCW'(4)) begin
                        n_nib[r_count[1:0]] = i_byte[3:0];
                    end
                    n_count = r_count + FCW'(1);
                end
            end
            default: begin
                n_step = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ST_IDLE;
            r_count <= '0;
            r_nib   <= '0;
            r_pend  <= DIGITS_RESET;
        end else if (i_step_en) begin
            r_step  <= n_step;
            r_count <= n_count;
            r_nib   <= n_nib;
            r_pend  <= n_pend;
        end
    end

    // The word after the closing comma, whatever it holds, yields the result.
    assign o_emit.emit   = (r_step > ST_CAPTURE);
    assign o_emit.digits = r_pend;

endmodule

`default_nettype wire

// ===== src/nrtc_disp.sv =====
// Display stage: shown digits, change detect, blink level and result register.
// Depends on nrtc_pkg.
`default_nettype none

module nrtc_disp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_proc,
    input  wire logic             i_adv,
    input  wire nrtc_pkg::t_emit  i_emit,
    output logic                  o_valid,
    output logic                  o_hour_tens,
    output logic [3:0]            o_hour_ones,
    output logic [3:0]            o_minute_tens,
    output logic [3:0]            o_minute_ones,
    output logic                  o_changed,
    output logic                  o_blink_level,
    output logic                  o_blank_lead
);
    import nrtc_pkg::*;

    logic     r_out_valid;
    logic     r_blink;
    t_digits  r_shown;
    t_digits  r_out_digits;
    logic     r_changed;
    logic     r_out_blink;
    logic     r_blank;
    logic     fire;
    logic     diff;
    t_digits  n_shown;

    always_comb begin
        fire    = i_proc && i_emit.emit;
        diff    = (i_emit.digits != r_shown);
        n_shown = diff ? i_emit.digits : r_shown;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_blink     <= 1'b1;
            r_shown     <= DIGITS_RESET;
        end else begin
            if (i_adv) begin
                r_out_valid <= fire;
            end
            if (fire) begin
                r_blink <= ~r_blink;
                r_shown <= n_shown;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_digits <= n_shown;
            r_changed    <= diff;
            r_out_blink  <= r_blink;
            r_blank      <= diff && !n_shown.hour_tens;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hour_tens   = r_out_digits.hour_tens;
    assign o_hour_ones   = r_out_digits.hour_ones;
    assign o_minute_tens = r_out_digits.minute_tens;
    assign o_minute_ones = r_out_digits.minute_ones;
    assign o_changed     = r_changed;
    assign o_blink_level = r_out_blink;
    assign o_blank_lead  = r_blank;

endmodule

`default_nettype wire

// ===== src/nrtc_checker.sv =====
// Port-level checker for the NMEA RMC time clock, bound to the top level.
// Depends on nmea_rmc_time_clock_core_defines.svh.
`default_nettype none

`include "nmea_rmc_time_clock_core_defines.svh"

module nrtc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic       o_hour_tens,
    input wire logic [3:0] o_hour_ones,
    input wire logic [3:0] o_minute_tens,
    input wire logic [3:0] o_minute_ones,
    input wire logic       o_changed,
    input wire logic       o_blink_level,
    input wire logic       o_blank_lead
);
    logic        r_last_blink;
    logic [12:0] r_last_digits;
    logic [12:0] digits;
    logic        out_take;

    assign digits   = {o_hour_tens, o_hour_ones, o_minute_tens, o_minute_ones};
    assign out_take = o_valid && !i_stall;

    // Last delivered word; before any word it matches the power-up display.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_blink  <= 1'b0;
            r_last_digits <= {1'b1, 4'd2, 4'd3, 4'd4};
        end else if (out_take) begin
            r_last_blink  <= o_blink_level;
            r_last_digits <= digits;
        end
    end

    `NRTC_ASSERT_NXT(a_held_word, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(digits) && $stable(o_changed) && $stable(o_blink_level) && $stable(o_blank_lead), "stalled result word changed")
    `NRTC_ASSERT_IMP(a_blink_toggle, i_clk, i_rst_n, o_valid, o_blink_level != r_last_blink, "blink level did not toggle")
    `NRTC_ASSERT_IMP(a_change_flag, i_clk, i_rst_n, o_valid, o_changed == (digits != r_last_digits), "change flag does not match digits")
    `NRTC_ASSERT_IMP(a_blank_lead, i_clk, i_rst_n, o_valid, o_blank_lead == (o_changed && !o_hour_tens), "leading blank flag wrong")

endmodule

bind nmea_rmc_time_clock_core nrtc_checker u_nrtc_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for nmea_rmc_time_clock_core: a sentence parser model runs beside the DUT.
// Needs only nrtc_pkg and the RTL; random gaps are applied on the input, random stalls on the output.

module tb_top;
    import nrtc_pkg::*;

    localparam int TOTAL_BYTES = 1400;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic       hour_tens;
        logic [3:0] hour_ones;
        logic [3:0] minute_tens;
        logic [3:0] minute_ones;
        logic       changed;
        logic       blink_level;
        logic       blank_lead;
    } t_clock_face;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_rx_byte;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [3:0] i_cfg_data;
    logic       o_valid;
    logic       i_stall;
    logic       o_hour_tens;
    logic [3:0] o_hour_ones;
    logic [3:0] o_minute_tens;
    logic [3:0] o_minute_ones;
    logic       o_changed;
    logic       o_blink_level;
    logic       o_blank_lead;

    // Parser model state.
    logic [7:0]  hdr_seq [0:6];
    logic [3:0]  hdr_pos;
    int unsigned time_len;
    logic [3:0]  time_nib [0:3];
    logic [3:0]  next_digits [0:3];
    logic [3:0]  lit_digits [0:3];
    logic        blink_next;
    logic [3:0]  tz_offset;

    t_clock_face due_faces [$];
    logic [7:0]  last_field [$];

    int  errors;
    int  faces_checked;
    int  rx_accepted;
    int  tz_writes;
    int  hold_cycles;
    int  longest_hold;
    bit  gapless;

    nmea_rmc_time_clock_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rx_byte     (i_rx_byte),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hour_tens   (o_hour_tens),
        .o_hour_ones   (o_hour_ones),
        .o_minute_tens (o_minute_tens),
        .o_minute_ones (o_minute_ones),
        .o_changed     (o_changed),
        .o_blink_level (o_blink_level),
        .o_blank_lead  (o_blank_lead)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] ERROR %s", $time, msg);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
            note_error($sformatf("display word %0d: %s expected %0d, got %0d",
                                 faces_checked, name, want, got));
    endfunction

    function automatic void reset_parser_model();
        hdr_seq = '{CHAR_DOLLAR, CHAR_G, CHAR_P, CHAR_R, CHAR_M, CHAR_C, CHAR_COMMA};
        hdr_pos = ST_IDLE;
        time_len = 0;
        for (int k = 0; k < 4; k++) begin
            time_nib[k]    = 4'd0;
            next_digits[k] = 4'(k + 1);
            lit_digits[k]  = 4'(k + 1);
        end
        blink_next = 1'b1;
        tz_offset  = TZ_RESET;
    endfunction

    // Local 12-hour time from the first four captured nibbles; zeros for seven bytes or fewer.
    function automatic void close_time_field();
        int unsigned hr;
        logic        tens;
        if (time_len > 7) begin
            hr = 10 * int'(time_nib[0]) + int'(time_nib[1]);
            if (hr > 12) hr -= 12;
            if (hr <= tz_offset) hr += 12;
            hr -= tz_offset;
            tens = (hr > 9);
            if (tens) hr -= 10;
            next_digits[0] = {3'b000, tens};
            next_digits[1] = hr[3:0];
            next_digits[2] = time_nib[2];
            next_digits[3] = time_nib[3];
        end else begin
            for (int k = 0; k < 4; k++) next_digits[k] = 4'd0;
        end
    endfunction

    // Advances the parser model by one character; returns 1 when a display word is due.
    function automatic bit parse_char(input logic [7:0] b, output t_clock_face face);
        bit moved;
        face  = '0;
        moved = 1'b0;
        if (hdr_pos < ST_CAPTURE) begin
            if (hdr_pos == ST_HDR_LAST) time_len = 0;
            // A mismatching character is dropped, not tried again as a dollar sign.
            if (b == hdr_seq[hdr_pos]) hdr_pos = hdr_pos + 4'd1;
            else hdr_pos = ST_IDLE;
            return 1'b0;
        end
        if (hdr_pos == ST_CAPTURE) begin
            if (b == CHAR_COMMA) begin
                close_time_field();
                time_len = 0;
                hdr_pos  = ST_EMIT;
            end else if (time_len < CAPTURE_LIMIT) begin
                if (time_len < 4) time_nib[time_len] = b[3:0];
                time_len++;
            end
            return 1'b0;
        end
        hdr_pos = ST_IDLE;
        face.blink_level = blink_next;
        blink_next = ~blink_next;
        for (int k = 0; k < 4; k++)
            if (next_digits[k] != lit_digits[k]) moved = 1'b1;
        if (moved)
            for (int k = 0; k < 4; k++) lit_digits[k] = next_digits[k];
        face.hour_tens   = lit_digits[0][0];
        face.hour_ones   = lit_digits[1];
        face.minute_tens = lit_digits[2];
        face.minute_ones = lit_digits[3];
        face.changed     = moved;
        face.blank_lead  = moved && (lit_digits[0] == 4'd0);
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gapless || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Called at a rising edge; returns at the edge where the word was taken.
    task automatic send_byte(input logic [7:0] b);
        int          gap;
        t_clock_face face;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        // Inputs only change at rising edges, so the falling edge shows the handshake.
        do @(negedge i_clk); while (o_stall !== 1'b0);
        if (parse_char(b, face)) due_faces.push_back(face);
        rx_accepted++;
        @(posedge i_clk);
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) send_byte(s[k]);
    endtask

    task automatic write_timezone(input logic [3:0] tz);
        i_valid <= 1'b0;
        while (due_faces.size() != 0) @(posedge i_clk);
        // A word that yields nothing may still sit in the pipeline.
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= tz;
        do @(negedge i_clk); while (o_cfg_ready !== 1'b1);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tz_offset = tz;
        tz_writes++;
    endtask

    // Full header, a new field of length len or the last one again, closing comma, emit word.
    task automatic send_sentence(input int len, input bit any_bytes, input bit repeat_last);
        logic [7:0] c;
        int         k;
        send_text("$GPRMC,");
        if (!repeat_last) begin
            last_field.delete();
            for (k = 0; k < len; k++) begin
                if (any_bytes && $urandom_range(0, 2) == 0) begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CHAR_COMMA) c = 8'h2E;
                end else begin
                    c = 8'h30 + 8'($urandom_range(0, 9));
                end
                last_field.push_back(c);
            end
        end
        foreach (last_field[m]) send_byte(last_field[m]);
        send_byte(CHAR_COMMA);
        send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic test_header_resync();
        send_byte(8'h00);
        // The second dollar sign breaks the match and the rest is ignored.
        send_text("$$GPRMC,");
    endtask

    task automatic test_long_field();
        send_text("$GPRMC,1J");
        send_byte(8'hFF);
        send_byte(8'h00);
        send_text("5959.000ABCDE,");
        send_byte(8'hFF);
    endtask

    task automatic test_short_field();
        send_text("$GPRMC,1234567,Q");
    endtask

    task automatic test_timezone_sweep();
        logic [3:0] zones [0:5];
        string      hours [0:4];
        zones = '{4'd0, 4'd11, 4'd1, 4'd10, 4'd7, TZ_RESET};
        hours = '{"00", "11", "12", "13", "23"};
        foreach (zones[z]) begin
            write_timezone(zones[z]);
            foreach (hours[h]) send_text({"$GPRMC,", hours[h], "0715.00,A"});
            send_text({"$GPRMC,", hours[4], "0715.00,A"});
        end
    endtask

    // The receiver holds off while sentences keep coming, so the DUT backs up.
    task automatic test_output_hold();
        gapless = 1'b1;
        hold_cycles = 80;
        send_text("$GPRMC,,A$GPRMC,,B$GPRMC,234500.00,C$GPRMC,,D");
        gapless = 1'b0;
    endtask

    function automatic int pick_field_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(8, 12);
        if (r < 85) return $urandom_range(0, 7);
        return $urandom_range(13, 20);
    endfunction

    task automatic test_random_traffic();
        int pick;
        int n;
        int k;
        while (rx_accepted < TOTAL_BYTES) begin
            gapless = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                send_sentence(pick_field_len(), $urandom_range(0, 3) == 0,
                              last_field.size() != 0 && $urandom_range(0, 3) == 0);
            end else if (pick < 82) begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++) send_byte(hdr_seq[k]);
                send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 97) begin
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++) send_byte(8'($urandom_range(0, 255)));
            end else begin
                write_timezone(4'($urandom_range(0, 11)));
            end
        end
        gapless = 1'b0;
    endtask

    // Output stall: alternating runs, plus a long hold on request.
    initial begin : result_stall_gen
        int run_left;
        int r;
        run_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                hold_cycles--;
                longest_hold++;
            end else if (run_left > 0) begin
                run_left--;
            end else if (i_stall) begin
                i_stall <= 1'b0;
                r = $urandom_range(0, 99);
                run_left = (r < 50) ? $urandom_range(1, 4) :
                           (r < 85) ? $urandom_range(5, 15) : $urandom_range(20, 60);
            end else begin
                i_stall <= 1'b1;
                r = $urandom_range(0, 99);
                run_left = (r < 70) ? $urandom_range(1, 3) :
                           (r < 95) ? $urandom_range(4, 10) : $urandom_range(20, 50);
            end
        end
    end

    initial begin : display_checker
        t_clock_face got;
        t_clock_face want;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
                got.hour_tens   = o_hour_tens;
                got.hour_ones   = o_hour_ones;
                got.minute_tens = o_minute_tens;
                got.minute_ones = o_minute_ones;
                got.changed     = o_changed;
                got.blink_level = o_blink_level;
                got.blank_lead  = o_blank_lead;
                if (due_faces.size() == 0) begin
                    note_error($sformatf("display word with none due: %h", got));
                end else begin
                    want = due_faces.pop_front();
                    check_field("hour_tens",   want.hour_tens,   got.hour_tens);
                    check_field("hour_ones",   want.hour_ones,   got.hour_ones);
                    check_field("minute_tens", want.minute_tens, got.minute_tens);
                    check_field("minute_ones", want.minute_ones, got.minute_ones);
                    check_field("changed",     want.changed,     got.changed);
                    check_field("blink_level", want.blink_level, got.blink_level);
                    check_field("blank_lead",  want.blank_lead,  got.blank_lead);
                    faces_checked++;
                end
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : run_tests
        int drain;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_rx_byte   = 8'h00;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 4'd0;
        i_stall     = 1'b0;
        gapless     = 1'b0;
        hold_cycles = 0;
        reset_parser_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_header_resync();
        test_long_field();
        test_short_field();
        test_timezone_sweep();
        test_output_hold();
        test_random_traffic();

        i_valid <= 1'b0;
        drain = 0;
        while (due_faces.size() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (due_faces.size() != 0)
            note_error($sformatf("%0d display words never arrived", due_faces.size()));

        $display("Checked %0d display words from %0d characters, %0d timezone writes,",
                 faces_checked, rx_accepted, tz_writes);
        $display("including %0d cycles of forced output hold.", longest_hold);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d errors", errors);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
